/* rtl/assert_macros.svh */
// Assertion macros used by the RTL file neighbour_mean_smoothing.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge, off while reset is held.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/nms_pkg.sv */
// Constants, types and the divide helper for the neighbour mean smoothing block.
package nms_pkg;

  localparam int PIX_W      = 8;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WCFG_W     = 11;
  localparam int HCFG_W     = 13;
  localparam int CFG_W      = 13;
  localparam int SUM_W      = PIX_W + 2;
  localparam int CNT_W      = 3;
  localparam int BURST_MAX  = 3;
  localparam int QDEPTH     = 16;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = QPTR_W + 1;

  // floor(x / 3) == (x * 683) >> 11 for every x below 2048
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SH    = 11;
  localparam int PROD_W     = SUM_W + DIV3_SH;

  // register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  // neighbour counts
  localparam logic [CNT_W-1:0] NB_ONE   = 3'd1;
  localparam logic [CNT_W-1:0] NB_TWO   = 3'd2;
  localparam logic [CNT_W-1:0] NB_THREE = 3'd3;
  localparam logic [CNT_W-1:0] NB_FOUR  = 3'd4;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic [COL_W-1:0] col_t;

  // one pending result before the divide
  typedef struct packed {
    sum_t sum;
    cnt_t cnt;
    row_t row;
    col_t col;
  } part_t;

  // one queued result
  typedef struct packed {
    pix_t smoothed;
    row_t row;
    col_t col;
    logic frame_end;
    logic burst_last;
  } result_t;

  function automatic pix_t floor_mean(sum_t sum, cnt_t cnt);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    case (cnt)
      NB_TWO:   floor_mean = pix_t'(sum >> 1);
      NB_THREE: floor_mean = prod[DIV3_SH +: PIX_W];
      NB_FOUR:  floor_mean = pix_t'(sum >> 2);
      default:  floor_mean = pix_t'(sum);
    endcase
  endfunction

endpackage

/* rtl/neighbour_mean_smoothing.sv */
// Four-neighbour mean smoothing filter: line memory, two compute stages, result queue.
//
//  channel | ports                                        | dir | handshake
//  --------+----------------------------------------------+-----+-----------------
//  input   | in_pixel_in                                  | in  | in_valid/in_stall
//  result  | out_smoothed out_row out_col out_frame_end   | out | out_valid/out_stall
//          | out_burst_last                               |     |
//  config  | cfg_index cfg_data                           | in  | cfg_we
//
// One pixel per cycle unless in_stall is high; stage 1 then stage 2 feed the queue.
// The line memory takes one read (next column) and one write per pixel.
// Last-row pixels give up to three results and the queue drains one a cycle when
// not stalled, so in_stall rises when the 16-entry queue cannot take another burst.
// Reset sets the default size, clears counters and queue; line memory is not cleared.
`include "assert_macros.svh"

module neighbour_mean_smoothing
  import nms_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_pixel_in,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] out_smoothed,
  output logic [ROW_W-1:0] out_row,
  output logic [COL_W-1:0] out_col,
  output logic             out_frame_end,
  output logic             out_burst_last,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // line memory entry: {older line, newer line}
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] mem_q_r;
  logic               fwd_hit_r;
  logic [2*PIX_W-1:0] fwd_data_r;
  logic [2*PIX_W-1:0] rd_ent;
  logic               mem_we;
  col_t               mem_wa;
  logic [2*PIX_W-1:0] mem_wd;

  col_t w_m1_r, w_m1_nxt;
  row_t h_m1_r, h_m1_nxt;
  col_t col_r, col_nxt;
  row_t row_r, row_nxt;
  col_t rd_addr;
  logic in_acc;

  logic [WCFG_W-1:0] cfg_w;
  logic [HCFG_W-1:0] cfg_h;

  // stage 1
  logic               s1_v_r;
  pix_t               s1_px_r;
  row_t               s1_row_r;
  col_t               s1_col_r;
  logic [2*PIX_W-1:0] cur_r;
  pix_t               prev_new_r;
  pix_t               lp_hi_r, lp_lo_r, lp_hi_nxt, lp_lo_nxt;

  pix_t        up_px, cur_new, right_px;
  logic        first_col, last_col, last_row, top_row;
  part_t [BURST_MAX-1:0] part;
  logic [1:0]  s1_n;

  // stage 2
  logic                  s2_v_r;
  logic [1:0]            s2_n_r;
  part_t [BURST_MAX-1:0] s2_part_r;

  // result queue
  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] q_wp_r, q_rp_r;
  logic [QCNT_W-1:0] q_cnt_r;
  logic [QCNT_W:0]   q_pend;
  logic [1:0]        push_n;
  logic              pop;
  result_t           q_head;

  // ---------------------------------------------------------------- input side
  always_comb begin
    q_pend = {1'b0, q_cnt_r}
           + (s1_v_r ? (QCNT_W+1)'(BURST_MAX) : '0)
           + (s2_v_r ? (QCNT_W+1)'(BURST_MAX) : '0);
    in_stall = q_pend > (QCNT_W+1)'(QDEPTH - BURST_MAX);
  end

  assign in_acc  = in_valid && !in_stall;
  assign rd_addr = (col_r == w_m1_r) ? '0 : col_r + 1'b1;
  assign cfg_w   = cfg_data[WCFG_W-1:0];
  assign cfg_h   = cfg_data[HCFG_W-1:0];

  always_comb begin
    w_m1_nxt  = w_m1_r;
    h_m1_nxt  = h_m1_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    lp_hi_nxt = lp_hi_r;
    lp_lo_nxt = lp_lo_r;
    if (s1_v_r) begin
      lp_hi_nxt = lp_lo_r;
      lp_lo_nxt = s1_px_r;
    end
    if (in_acc) begin
      if (col_r == w_m1_r) begin
        col_nxt = '0;
        row_nxt = (row_r == h_m1_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH: begin
          if (cfg_w < WCFG_W'(2))              w_m1_nxt = col_t'(1);
          else if (cfg_w > WCFG_W'(MAX_WIDTH)) w_m1_nxt = col_t'(MAX_WIDTH - 1);
          else                                 w_m1_nxt = col_t'(cfg_w - 1'b1);
        end
        CFG_FRAME_HEIGHT: begin
          if (cfg_h < HCFG_W'(2))               h_m1_nxt = row_t'(1);
          else if (cfg_h > HCFG_W'(MAX_HEIGHT)) h_m1_nxt = row_t'(MAX_HEIGHT - 1);
          else                                  h_m1_nxt = row_t'(cfg_h - 1'b1);
        end
        default: ;
      endcase
      // any write restarts the frame
      col_nxt   = '0;
      row_nxt   = '0;
      lp_hi_nxt = '0;
      lp_lo_nxt = '0;
    end
  end

  // ---------------------------------------------------------------- line memory
  always_ff @(posedge clk) begin
    if (mem_we) line_mem[mem_wa] <= mem_wd;
    if (in_acc) mem_q_r <= line_mem[rd_addr];
  end

  // write and read of the same entry on one edge: hand over the new data
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_hit_r  <= mem_we && (mem_wa == rd_addr);
      fwd_data_r <= mem_wd;
    end
  end

  assign rd_ent = fwd_hit_r ? fwd_data_r : mem_q_r;

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r  <= in_pixel_in;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
      cur_r    <= rd_ent;   // right-hand entry of the previous pixel
    end
    if (s1_v_r) prev_new_r <= cur_r[PIX_W-1:0];
  end

  always_comb begin
    up_px     = cur_r[2*PIX_W-1:PIX_W];
    cur_new   = cur_r[PIX_W-1:0];
    right_px  = rd_ent[PIX_W-1:0];
    first_col = (s1_col_r == '0);
    last_col  = (s1_col_r == w_m1_r);
    last_row  = (s1_row_r == h_m1_r);
    top_row   = (s1_row_r == '0);

    mem_we = s1_v_r;
    mem_wa = s1_col_r;
    mem_wd = {(top_row ? up_px : cur_new), s1_px_r};

    // pixel above this one: down neighbour is the new pixel
    part[0].sum = sum_t'(s1_px_r);
    part[0].cnt = NB_ONE;
    if (s1_row_r > row_t'(1)) begin
      part[0].sum = part[0].sum + sum_t'(up_px);
      part[0].cnt = part[0].cnt + 1'b1;
    end
    if (!first_col) begin
      part[0].sum = part[0].sum + sum_t'(prev_new_r);
      part[0].cnt = part[0].cnt + 1'b1;
    end
    if (!last_col) begin
      part[0].sum = part[0].sum + sum_t'(right_px);
      part[0].cnt = part[0].cnt + 1'b1;
    end
    part[0].row = s1_row_r - 1'b1;
    part[0].col = s1_col_r;

    // last row, one pixel behind
    part[1].sum = sum_t'(s1_px_r) + sum_t'(prev_new_r)
                + ((s1_col_r > col_t'(1)) ? sum_t'(lp_hi_r) : '0);
    part[1].cnt = (s1_col_r > col_t'(1)) ? NB_THREE : NB_TWO;
    part[1].row = s1_row_r;
    part[1].col = s1_col_r - 1'b1;

    // bottom-right corner
    part[2].sum = sum_t'(cur_new) + sum_t'(lp_lo_r);
    part[2].cnt = NB_TWO;
    part[2].row = s1_row_r;
    part[2].col = s1_col_r;

    if (top_row)       s1_n = 2'd0;
    else if (last_row) s1_n = 2'd1 + 2'(!first_col) + 2'(last_col);
    else               s1_n = 2'd1;
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_n_r    <= s1_n;
      s2_part_r <= part;
    end
  end

  assign push_n = s2_v_r ? s2_n_r : 2'd0;
  assign pop    = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    for (int k = 0; k < BURST_MAX; k++) begin
      if (2'(k) < push_n) begin
        q_r[q_wp_r + QPTR_W'(k)] <= '{
          smoothed:   floor_mean(s2_part_r[k].sum, s2_part_r[k].cnt),
          row:        s2_part_r[k].row,
          col:        s2_part_r[k].col,
          frame_end:  (k == BURST_MAX - 1),
          burst_last: (2'(k) == push_n - 2'd1)
        };
      end
    end
  end

  // ---------------------------------------------------------------- control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_m1_r  <= col_t'(MAX_WIDTH - 1);
      h_m1_r  <= row_t'(1024 - 1);
      col_r   <= '0;
      row_r   <= '0;
      lp_hi_r <= '0;
      lp_lo_r <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      q_wp_r  <= '0;
      q_rp_r  <= '0;
      q_cnt_r <= '0;
    end else begin
      w_m1_r  <= w_m1_nxt;
      h_m1_r  <= h_m1_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      lp_hi_r <= lp_hi_nxt;
      lp_lo_r <= lp_lo_nxt;
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r && (s1_n != 2'd0);
      q_wp_r  <= q_wp_r + QPTR_W'(push_n);
      q_rp_r  <= q_rp_r + QPTR_W'(pop);
      q_cnt_r <= q_cnt_r + QCNT_W'(push_n) - QCNT_W'(pop);
    end
  end

  // ---------------------------------------------------------------- output
  assign q_head         = q_r[q_rp_r];
  assign out_valid      = (q_cnt_r != '0);
  assign out_smoothed   = q_head.smoothed;
  assign out_row        = q_head.row;
  assign out_col        = q_head.col;
  assign out_frame_end  = q_head.frame_end;
  assign out_burst_last = q_head.burst_last;

  // ---------------------------------------------------------------- checks
  `ASSERT_CLK(a_q_no_overflow, q_cnt_r <= QCNT_W'(QDEPTH), "result queue overflow")
  `ASSERT_CLK(a_col_in_frame, col_r <= w_m1_r, "column counter past frame width")
  `ASSERT_IMPLY(a_fend_closes_burst, out_valid && out_frame_end, out_burst_last, "frame end not last of burst")

endmodule

/* bench/neighbour_mean_smoothing_tb.sv */
// Self-checking testbench for the four-neighbour mean smoothing filter.
`timescale 1ns / 1ps

module neighbour_mean_smoothing_tb
  import nms_pkg::*;
;

  localparam int ANY        = -1;
  localparam int SETTLE     = 8;
  localparam int DRAIN      = 20;
  localparam int HOLD_LEN   = 120;
  localparam int WIDE_PX    = 16;
  localparam int TALL_PX    = 48;
  localparam int TALL_HOLD  = 8;
  localparam int RAND_ITEMS = 290;

  typedef enum logic {STEP_PIXEL, STEP_CFG} step_t;
  typedef enum int {FLOW, LIGHT, HEAVY, PERIODIC} stall_mode_t;

  typedef struct packed {
    step_t            kind;
    logic             idx;
    logic [CFG_W-1:0] data;
    logic [PIX_W-1:0] px;
    int               want_n;
    int               want_mean;
  } dir_row_t;

  // typed counts in the first frames, means only where the frame is flat
  localparam dir_row_t DIRECTED [24] = '{
    // default size after reset: first row is stored only
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h00, 0, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hFF, 0, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hA5, 0, ANY},
    // both below 2, taken as 2; the write also restarts the frame
    '{STEP_CFG,   CFG_FRAME_WIDTH,  13'h0000, 8'h00, ANY, ANY},
    '{STEP_CFG,   CFG_FRAME_HEIGHT, 13'h0001, 8'h00, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hFF, 0, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hFF, 0, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hFF, 1, 255},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hFF, 3, 255},
    // next frame follows straight on
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h00, 0, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h00, 0, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h00, 1, 0},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h00, 3, 0},
    // upper bits of the width write are dropped: 3 columns
    '{STEP_CFG,   CFG_FRAME_WIDTH,  13'h0803, 8'h00, ANY, ANY},
    '{STEP_CFG,   CFG_FRAME_HEIGHT, 13'h0003, 8'h00, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h01, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h80, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hFF, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h7E, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h00, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hC3, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h55, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'hAA, ANY, ANY},
    '{STEP_PIXEL, CFG_FRAME_WIDTH,  13'h0000, 8'h3C, ANY, ANY}
  };

  logic             clk;
  logic             rst_n        = 1'b0;
  logic             in_valid     = 1'b0;
  logic             in_stall;
  logic [PIX_W-1:0] in_pixel_in  = '0;
  logic             out_valid;
  logic             out_stall    = 1'b0;
  logic [PIX_W-1:0] out_smoothed;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;
  logic             out_frame_end;
  logic             out_burst_last;
  logic             cfg_we       = 1'b0;
  logic             cfg_index    = 1'b0;
  logic [CFG_W-1:0] cfg_data     = '0;

  neighbour_mean_smoothing dut (.*);

  // predictor state
  logic [PIX_W-1:0] older_mem [MAX_WIDTH];
  logic [PIX_W-1:0] newer_mem [MAX_WIDTH];
  int unsigned      cur_row, cur_col;
  int unsigned      frm_w, frm_h;
  logic [15:0]      last_two;

  result_t smoothed_q [$];
  result_t burst_res [3];
  int      burst_n;
  int      errors     = 0;
  int      burst_left = 16;
  bit      hold_req   = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic result_t mean_result(int unsigned sum, int unsigned cnt,
                                          int unsigned r, int unsigned c, logic fend);
    result_t res;
    res.smoothed   = PIX_W'(sum / cnt);
    res.row        = ROW_W'(r);
    res.col        = COL_W'(c);
    res.frame_end  = fend;
    res.burst_last = 1'b0;
    return res;
  endfunction

  // works out the results released by one accepted pixel
  function automatic void smooth_pixel(logic [PIX_W-1:0] px);
    int unsigned r, c, sum, cnt;
    r = cur_row;
    c = cur_col;
    burst_n = 0;
    if (c >= frm_w || r >= frm_h) begin
      r = 0;
      c = 0;
    end
    if (r == 0) begin
      newer_mem[c] = px;
    end else begin
      sum = px;
      cnt = 1;
      if (r > 1) begin
        sum += older_mem[c];
        cnt++;
      end
      if (c > 0) begin
        sum += older_mem[c-1];
        cnt++;
      end
      if (c + 1 < frm_w) begin
        sum += newer_mem[c+1];
        cnt++;
      end
      burst_res[burst_n] = mean_result(sum, cnt, r - 1, c, 1'b0);
      burst_n++;
      older_mem[c] = newer_mem[c];
      newer_mem[c] = px;
      if (r == frm_h - 1) begin
        // bottom row trails the input by one pixel
        if (c > 0) begin
          sum = px + older_mem[c-1];
          cnt = 2;
          if (c > 1) begin
            sum += last_two[15:8];
            cnt++;
          end
          burst_res[burst_n] = mean_result(sum, cnt, r, c - 1, 1'b0);
          burst_n++;
        end
        if (c == frm_w - 1) begin
          sum = 32'(older_mem[c]) + 32'(last_two[7:0]);
          burst_res[burst_n] = mean_result(sum, 2, r, c, 1'b1);
          burst_n++;
        end
      end
    end
    last_two = {last_two[7:0], px};
    if (c + 1 < frm_w) begin
      c++;
    end else begin
      c = 0;
      r = (r + 1 < frm_h) ? r + 1 : 0;
    end
    cur_row = r;
    cur_col = c;
    if (burst_n > 0) burst_res[burst_n-1].burst_last = 1'b1;
    for (int i = 0; i < burst_n; i++) smoothed_q.push_back(burst_res[i]);
  endfunction

  function automatic void cmp_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // one request; the sender idles in bursts
  task automatic push_pixel(logic [PIX_W-1:0] px);
    in_valid    <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    smooth_pixel(px);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 80 : $urandom_range(1, 20);
    end
  endtask

  // registers change only once the pipe has emptied
  task automatic write_reg(logic idx, logic [CFG_W-1:0] data);
    if (in_valid) in_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FRAME_WIDTH)
      frm_w = clamp_size(data[WCFG_W-1:0], MAX_WIDTH);
    else
      frm_h = clamp_size(data[HCFG_W-1:0], MAX_HEIGHT);
    cur_row  = 0;
    cur_col  = 0;
    last_two = '0;
  endtask

  // result side: check, then pick the next stall
  initial begin
    result_t     want;
    stall_mode_t mode;
    int          mode_left;
    int          hold_left;
    logic        stall;
    mode      = FLOW;
    mode_left = 0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (smoothed_q.size() == 0) begin
          $display("%0t: unexpected result expected none actual row %0d col %0d",
                   $time, out_row, out_col);
          errors++;
        end else begin
          want = smoothed_q.pop_front();
          cmp_field("smoothed",   want.smoothed,   out_smoothed);
          cmp_field("row",        want.row,        out_row);
          cmp_field("col",        want.col,        out_col);
          cmp_field("frame_end",  want.frame_end,  out_frame_end);
          cmp_field("burst_last", want.burst_last, out_burst_last);
        end
      end
      if (mode_left == 0) begin
        mode      = stall_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 150);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        stall = 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN;
        stall     = 1'b1;
      end else begin
        case (mode)
          FLOW:    stall = 1'b0;
          LIGHT:   stall = ($urandom_range(0, 3) == 0);
          HEAVY:   stall = ($urandom_range(0, 3) != 0);
          default: stall = (mode_left % 3 == 0);
        endcase
      end
      out_stall <= stall;
    end
  end

  initial begin
    int unsigned n, frame_px, rand_sent;
    frm_w     = MAX_WIDTH;
    frm_h     = 1024;
    cur_row   = 0;
    cur_col   = 0;
    last_two  = '0;
    rand_sent = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == STEP_CFG) begin
        write_reg(DIRECTED[i].idx, DIRECTED[i].data);
      end else begin
        push_pixel(DIRECTED[i].px);
        if (DIRECTED[i].want_n != ANY)
          cmp_field("result count", DIRECTED[i].want_n, burst_n);
        if (DIRECTED[i].want_mean != ANY)
          for (int k = 0; k < burst_n; k++)
            cmp_field("flat mean", DIRECTED[i].want_mean, burst_res[k].smoothed);
      end
    end

    // widest frame, then tallest; both writes above the maximum
    write_reg(CFG_FRAME_WIDTH, 13'h1FFF);
    write_reg(CFG_FRAME_HEIGHT, 13'h0001);
    for (int i = 0; i < WIDE_PX; i++)
      push_pixel($urandom_range(0, 255));
    write_reg(CFG_FRAME_WIDTH, 13'h0000);
    write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    for (int i = 0; i < TALL_PX; i++) begin
      if (i == TALL_HOLD) hold_req = 1'b1;
      push_pixel($urandom_range(0, 255));
    end

    // small random frames; partial ones are cut short by a register write
    write_reg(CFG_FRAME_WIDTH, 13'(3));
    write_reg(CFG_FRAME_HEIGHT, 13'(4));
    while (rand_sent < RAND_ITEMS) begin
      case ($urandom_range(0, 2))
        0: write_reg(CFG_FRAME_WIDTH, ($urandom_range(0, 7) == 0) ?
                     13'($urandom_range(10, 40)) : 13'($urandom_range(0, 9)));
        1: write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(0, 8)));
        default: begin
          write_reg(CFG_FRAME_WIDTH, 13'($urandom_range(0, 9)));
          write_reg(CFG_FRAME_HEIGHT, 13'($urandom_range(0, 8)));
        end
      endcase
      frame_px = frm_w * frm_h;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, frame_px) :
          frame_px * $urandom_range(1, 2);
      if (n > RAND_ITEMS - rand_sent) n = RAND_ITEMS - rand_sent;
      repeat (n) push_pixel($urandom_range(0, 255));
      rand_sent += n;
    end

    if (in_valid) in_valid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
